// ----- hdl/shs_pkg.sv -----
// shared constants, gap table and controller/datapath types of the shellsort engine
package shs_pkg;

  localparam int PORT_KEY_W      = 32;
  localparam int DEF_STORE_DEPTH = 64;
  localparam int DEF_KEY_WIDTH   = 32;

  localparam int GAP_W = 7;
  localparam int GAP_N = 4;
  localparam int LVL_W = 2;

  localparam logic [GAP_W-1:0] GAP_TABLE [GAP_N] = '{7'd1, 7'd8, 7'd23, 7'd77};

  typedef enum logic [1:0] {
    RD_OUTER  = 2'd0,
    RD_INNER  = 2'd1,
    RD_INNER2 = 2'd2,
    RD_EMIT   = 2'd3
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_LOAD  = 2'd1,
    WR_MOVE  = 2'd2,
    WR_PLACE = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic    set_level;
    logic    pass_start;
    logic    level_down;
    logic    j_load;
    logic    hold;
    logic    out_load;
    logic    emit_step;
    logic    finish;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
  } shs_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic level_zero;
    logic inner_more;
    logic key_less;
    logic emit_last;
    logic out_valid;
  } shs_sts_t;

endpackage

// ----- hdl/shs_stream_if.sv -----
// valid/ready channel interfaces for key input and sorted key output
interface shs_in_if import shs_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [PORT_KEY_W-1:0] key_in;
  logic                         is_last;

  modport source (output valid, output key_in, output is_last, input ready);
  modport sink (input valid, input key_in, input is_last, output ready);
endinterface

interface shs_out_if import shs_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [PORT_KEY_W-1:0] key_out;
  logic                         end_of_set;

  modport source (output valid, output key_out, output end_of_set, input ready);
  modport sink (input valid, input key_out, input end_of_set, output ready);
endinterface

// ----- hdl/shs_dp.sv -----
// shellsort datapath: key store, indices, held key and output register
module shs_dp import shs_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  shs_cmd_t                     cmd,
  output shs_sts_t                     sts,
  input  logic signed [PORT_KEY_W-1:0] key_in,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [PORT_KEY_W-1:0] key_out,
  output logic                         end_of_set
);

  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int XW = (CW > GAP_W) ? CW : GAP_W;

  logic signed [KEY_WIDTH-1:0] mem [STORE_DEPTH];
  logic signed [KEY_WIDTH-1:0] rd_data;
  logic signed [KEY_WIDTH-1:0] held;
  logic signed [KEY_WIDTH-1:0] wr_data;
  logic [CW-1:0]    count;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic [CW-1:0]    e;
  logic [CW-1:0]    h;
  logic [CW-1:0]    jm;
  logic [CW-1:0]    jmm;
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] start_lvl;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;
  logic             wr_en;
  logic             full;

  assign h    = CW'(GAP_TABLE[level]);
  assign jm   = j - h;
  assign jmm  = jm - h;
  assign full = (count >= CW'(STORE_DEPTH));

  // largest gap below the key count, gap 1 at least
  always_comb begin
    start_lvl = '0;
    for (int k = 1; k < GAP_N; k++) begin
      if (XW'(GAP_TABLE[k]) < XW'(count)) begin
        start_lvl = LVL_W'(k);
      end
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_OUTER:  rd_addr = i[IW-1:0];
      RD_INNER:  rd_addr = jm[IW-1:0];
      RD_INNER2: rd_addr = jmm[IW-1:0];
      default:   rd_addr = e[IW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j[IW-1:0];
    wr_data = held;
    case (cmd.wr_sel)
      WR_LOAD: begin
        wr_en   = !full;
        wr_addr = count[IW-1:0];
        wr_data = KEY_WIDTH'(key_in);
      end
      WR_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      WR_PLACE: begin
        wr_en = 1'b1;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // key store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      level     <= '0;
      i         <= '0;
      j         <= '0;
      e         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count <= '0;
      end else if (cmd.wr_sel == WR_LOAD && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.set_level) begin
        level <= start_lvl;
      end else if (cmd.level_down) begin
        level <= level - 1'b1;
      end
      if (cmd.pass_start) begin
        i <= h;
      end else if (cmd.wr_sel == WR_PLACE) begin
        i <= i + 1'b1;
      end
      if (cmd.j_load) begin
        j <= i;
      end else if (cmd.wr_sel == WR_MOVE) begin
        j <= jm;
      end
      if (cmd.finish) begin
        e <= '0;
      end else if (cmd.emit_step) begin
        e <= e + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      held <= rd_data;
    end
    if (cmd.out_load) begin
      key_out    <= PORT_KEY_W'(rd_data);
      end_of_set <= (e + 1'b1 == count);
    end
  end

  assign sts.pass_done  = (i >= count);
  assign sts.level_zero = (level == '0);
  assign sts.inner_more = (jm >= h);
  assign sts.key_less   = (held < rd_data);
  assign sts.emit_last  = end_of_set;
  assign sts.out_valid  = out_valid;

`ifndef SYNTH
  a_move_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_sel == WR_MOVE |-> (j >= h) && (j < count))
    else $error("shift move outside the held keys");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (e < count))
    else $error("emit index beyond key count");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_out) && $stable(end_of_set))
    else $error("sorted key changed while waiting for transfer");
`endif

endmodule

// ----- hdl/shs_ctrl.sv -----
// shellsort controller: load, gap passes of insertion sort, emit sequencing
module shs_ctrl import shs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_is_last,
  input  logic     out_ready,
  input  shs_sts_t sts,
  output logic     in_ready,
  output shs_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_LOAD      = 9'b000000001,
    S_INIT      = 9'b000000010,
    S_PASS      = 9'b000000100,
    S_OUTER     = 9'b000001000,
    S_HOLD      = 9'b000010000,
    S_CMP       = 9'b000100000,
    S_PLACE     = 9'b001000000,
    S_EMIT_RD   = 9'b010000000,
    S_EMIT_WAIT = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit_ld;
  logic   emit_ld_next;

  always_comb begin
    state_next   = state;
    emit_ld_next = 1'b0;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_sel   = RD_EMIT;
    cmd.wr_sel   = WR_NONE;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_sel = WR_LOAD;
          if (in_is_last) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.set_level = 1'b1;
        state_next    = S_PASS;
      end
      S_PASS: begin
        cmd.pass_start = 1'b1;
        state_next     = S_OUTER;
      end
      S_OUTER: begin
        if (sts.pass_done) begin
          if (sts.level_zero) begin
            state_next = S_EMIT_RD;
          end else begin
            cmd.level_down = 1'b1;
            state_next     = S_PASS;
          end
        end else begin
          cmd.rd_sel = RD_OUTER;
          cmd.j_load = 1'b1;
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        cmd.hold   = 1'b1;
        cmd.rd_sel = RD_INNER;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.key_less) begin
          cmd.wr_sel = WR_MOVE;
          if (sts.inner_more) begin
            cmd.rd_sel = RD_INNER2;
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          cmd.wr_sel = WR_PLACE;
          state_next = S_OUTER;
        end
      end
      S_PLACE: begin
        cmd.wr_sel = WR_PLACE;
        state_next = S_OUTER;
      end
      S_EMIT_RD: begin
        emit_ld_next = 1'b1;
        state_next   = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        // on entry, while emit_ld is set, this state loads the output register from the store read
        if (emit_ld) begin
          cmd.out_load = 1'b1;
        end else if (sts.out_valid && out_ready) begin
          if (sts.emit_last) begin
            cmd.finish = 1'b1;
            state_next = S_LOAD;
          end else begin
            cmd.emit_step = 1'b1;
            state_next    = S_EMIT_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      emit_ld <= 1'b0;
    end else begin
      state   <= state_next;
      emit_ld <= emit_ld_next;
    end
  end

`ifndef SYNTH
  a_load_excl_emit: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.out_valid)
    else $error("input open while a sorted key is pending");

  a_cmp_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_HOLD || $past(state) == S_CMP)
    else $error("compare state entered without a held key");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state is not one-hot");
`endif

endmodule

// ----- hdl/shellsort_engine.sv -----
// Shellsort engine top level. Keys are loaded one transfer per cycle until a transfer
// with is_last; keys beyond STORE_DEPTH are dropped, but a dropped key with is_last still
// ends the set. The set is then sorted ascending with gaps 1, 8, 23, 77 (largest gap below
// the count first, gap 1 always) and streamed out with end_of_set on the final key; no new
// input is taken until the last sorted key has been transferred. Timing is set by the
// key store, which has one write port and one registered read port: each insertion step
// reads and holds a key, then shifts larger keys up by the gap until it can be placed,
// and each emitted key is read, registered and held until the sink takes it before the
// next key is read.
module shellsort_engine import shs_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  shs_in_if.sink    in_ch,
  shs_out_if.source out_ch
);

  shs_cmd_t cmd;
  shs_sts_t sts;

  shs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_is_last (in_ch.is_last),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .in_ready   (in_ch.ready),
    .cmd        (cmd)
  );

  shs_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .key_in     (in_ch.key_in),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .key_out    (out_ch.key_out),
    .end_of_set (out_ch.end_of_set)
  );

endmodule

// ----- bench/shellsort_engine_test.sv -----
// self-checking bench for the shellsort engine: directed and random key sets vs. a shellsort predictor
module shellsort_engine_test;
  import shs_pkg::*;

  localparam int STORE_DEPTH  = DEF_STORE_DEPTH;
  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_ITEMS = 270;
  localparam int SHELL_GAPS [4] = '{1, 8, 23, 77};

  typedef logic signed [PORT_KEY_W-1:0] key_t;

  typedef struct packed {
    logic signed [PORT_KEY_W-1:0] key;
    logic                         eos;
  } sorted_key_t;

  typedef struct packed {
    logic signed [PORT_KEY_W-1:0] key;
    logic                         last;
    logic                         typed;
  } plan_row_t;

  typedef enum int {
    KEYS_RANDOM,
    KEYS_CLUSTERED,
    KEYS_RISING,
    KEYS_FALLING,
    KEYS_EXTREME
  } key_mix_t;

  // typed rows are single-key sets: the sorted output is the key itself with end_of_set
  localparam plan_row_t DIRECTED_ROWS [19] = '{
    '{32'sh8000_0000, 1'b1, 1'b1},
    '{32'sh7fff_ffff, 1'b1, 1'b1},
    '{32'sh0000_0000, 1'b1, 1'b1},
    '{32'shffff_ffff, 1'b1, 1'b1},
    '{32'sh7fff_ffff, 1'b0, 1'b0},
    '{32'sh8000_0000, 1'b1, 1'b0},
    '{32'sh0000_0005, 1'b0, 1'b0},
    '{32'sh0000_0005, 1'b0, 1'b0},
    '{32'shffff_fffd, 1'b1, 1'b0},
    '{32'sh5555_5555, 1'b0, 1'b0},
    '{32'shaaaa_aaaa, 1'b0, 1'b0},
    '{32'sh0000_0007, 1'b0, 1'b0},
    '{32'shffff_fff9, 1'b0, 1'b0},
    '{32'sh7fff_fffe, 1'b0, 1'b0},
    '{32'sh8000_0001, 1'b0, 1'b0},
    '{32'sh0000_0064, 1'b0, 1'b0},
    '{32'shffff_ff9c, 1'b0, 1'b0},
    '{32'sh0000_0000, 1'b0, 1'b0},
    '{32'sh0000_0001, 1'b1, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;

  shs_in_if  in_ch ();
  shs_out_if out_ch ();

  shellsort_engine dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  key_t        held_keys [STORE_DEPTH];
  int          held_n;
  sorted_key_t sorted_q [$];
  bit          typed_q [$];
  bit          steady;
  int          errors;
  int          cycles;
  int          items_sent;
  int          sets_done;
  int          keys_checked;
  int          keys_dropped;

  task automatic report(input string msg);
    if (errors < 40) $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // load one key; on the final key shellsort the held set and queue it in order
  function automatic void take_key(input key_t key, input bit last);
    int   lvl;
    int   h;
    int   j;
    key_t v;
    if (held_n < STORE_DEPTH) begin
      held_keys[held_n] = key;
      held_n++;
    end else begin
      keys_dropped++;
    end
    if (!last) return;
    lvl = 0;
    while (lvl < 3 && SHELL_GAPS[lvl + 1] < held_n) lvl++;
    for (int l = lvl; l >= 0; l--) begin
      h = SHELL_GAPS[l];
      for (int o = h; o < held_n; o++) begin
        v = held_keys[o];
        j = o;
        while (j >= h && v < held_keys[j - h]) begin
          held_keys[j] = held_keys[j - h];
          j -= h;
        end
        held_keys[j] = v;
      end
    end
    for (int i = 0; i < held_n; i++) sorted_q.push_back('{held_keys[i], i == held_n - 1});
    held_n = 0;
    sets_done++;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    sorted_key_t want;
    bit          typed;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (sorted_q.size() == 0) begin
          report($sformatf("key %0d with end_of_set %0b and nothing pending",
                           out_ch.key_out, out_ch.end_of_set));
        end else begin
          want = sorted_q.pop_front();
          keys_checked++;
          if (out_ch.key_out !== want.key)
            report($sformatf("key_out %0d, want %0d", out_ch.key_out, want.key));
          if (out_ch.end_of_set !== want.eos)
            report($sformatf("end_of_set %0b, want %0b", out_ch.end_of_set, want.eos));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        typed = typed_q.pop_front();
        if (typed) begin
          sorted_q.push_back('{in_ch.key_in, 1'b1});
          sets_done++;
        end else begin
          take_key(in_ch.key_in, in_ch.is_last);
        end
      end
    end
  end

  function automatic int pick_pause();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // receiver with random stalls
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pick_pause();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_key(input key_t key, input bit last, input bit typed);
    int pause_len;
    pause_len = pick_pause();
    if (pause_len > 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause_len) @(negedge clk);
    end
    typed_q.push_back(typed);
    in_ch.valid   <= 1'b1;
    in_ch.key_in  <= key;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic key_t pick_key(input key_mix_t mix, input int i, input int n);
    case (mix)
      KEYS_RANDOM:    return key_t'($urandom);
      KEYS_CLUSTERED: return key_t'(int'($urandom_range(0, 8)) - 4);
      KEYS_RISING:    return key_t'(i * 1000 - 30000 + int'($urandom_range(0, 3)));
      KEYS_FALLING:   return key_t'((n - i) * 37 - 1000);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
    endcase
  endfunction

  task automatic send_set(input int n, input key_mix_t mix);
    for (int i = 0; i < n; i++) send_key(pick_key(mix, i, n), i == n - 1, 1'b0);
  endtask

  task automatic drain();
    while (sorted_q.size() != 0 || typed_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int       n;
    key_mix_t mix;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.key_in  = '0;
    in_ch.is_last = 1'b0;
    steady        = 1'b0;
    held_n        = 0;
    errors        = 0;
    cycles        = 0;
    items_sent    = 0;
    sets_done     = 0;
    keys_checked  = 0;
    keys_dropped  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED_ROWS[r])
      send_key(DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed);

    // full store, then a set that overflows and ends on a dropped key
    send_set(STORE_DEPTH, KEYS_RANDOM);
    send_set(STORE_DEPTH + 3, KEYS_FALLING);
    in_ch.valid <= 1'b0;
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 19))
        0:            n = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
        1, 2, 3:      n = $urandom_range(17, 40);
        default:      n = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       mix = KEYS_CLUSTERED;
        1:       mix = KEYS_RISING;
        2:       mix = KEYS_FALLING;
        3:       mix = KEYS_EXTREME;
        default: mix = KEYS_RANDOM;
      endcase
      send_set(n, mix);
      if ($urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        drain();
      end
    end
    in_ch.valid <= 1'b0;
    steady = 1'b0;

    drain();
    repeat (40) @(negedge clk);
    if (sorted_q.size() != 0) report($sformatf("%0d sorted keys never arrived", sorted_q.size()));

    $display("%0d key sets sorted, %0d keys past the store depth dropped",
             sets_done, keys_dropped);
    $display("%0d sorted keys compared, %0d mismatches", keys_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/shs_pkg.sv
hdl/shs_stream_if.sv
hdl/shs_dp.sv
hdl/shs_ctrl.sv
hdl/shellsort_engine.sv
bench/shellsort_engine_test.sv
